FILE: sv/axsb_pkg.sv
// Shared types and codes of the AXI to simple bus bridge.
// Depends on nothing; every other file uses it by scoped names.
package axsb_pkg;

  // Channel event codes on the input side.
  localparam logic [1:0] ACT_RD_ADDR = 2'd0;
  localparam logic [1:0] ACT_WR_ADDR = 2'd1;
  localparam logic [1:0] ACT_WR_BEAT = 2'd2;
  localparam logic [1:0] ACT_BUS_RSP = 2'd3;

  // Burst type codes.
  localparam logic [1:0] BURST_FIXED = 2'd0;
  localparam logic [1:0] BURST_WRAP  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_BUS_REQ = 2'd0;
  localparam logic [1:0] KIND_R_BEAT  = 2'd1;
  localparam logic [1:0] KIND_B_RESP  = 2'd2;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // AXI response codes.
  localparam logic [1:0] RESP_OKAY   = 2'd0;
  localparam logic [1:0] RESP_SLVERR = 2'd2;

  // Result queue geometry.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Burst phase, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_RD   = 3'b010,
    PH_WR   = 3'b100
  } phase_t;

  // One input transaction.
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  txn_id;
    logic [31:0] start_addr;
    logic [7:0]  burst_len;
    logic [2:0]  beat_size;
    logic [1:0]  burst_type;
    logic [31:0] wdata;
    logic [3:0]  wstrobe;
    logic        wlast;
    logic        rsp_ok;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_id;
    logic [31:0] bus_addr;
    logic [31:0] out_data;
    logic [3:0]  bus_strobe;
    logic        bus_is_write;
    logic [31:0] bus_tag;
    logic [1:0]  axi_resp;
    logic        rbeat_last;
    logic        run_last;
  } result_t;

  // All results that one input transaction causes.
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } q_entry_t;

endpackage

FILE: sv/axi_to_simple_bus_bridge_unit.sv
// Top level of the AXI burst to simple bus bridge.
// Depends on axsb_pkg, axsb_front, axsb_queue and axsb_back.
//
// Usage: each input transaction is one channel event (read address, write
// address, write data beat or bus response), offered on in_valid/in_ready.
// Every result (a bus request, an AXI read beat, an AXI write response or an
// ignored marker) leaves on out_valid/out_ready, with out_run_last set on the
// final result of each input transaction. Events offered in the wrong phase
// yield one ignored result and change nothing.
// With the queue empty, a result is presented in the cycle after its input is
// accepted; otherwise it waits behind the queued results.
// Throughput: one input transaction per cycle while the queue is not full. A
// read response that also issues the next bus read yields two results, which
// leave one after the other through the single result port.
// The front state machine updates in the accept cycle; a four-entry queue of
// result groups decouples it from the output side, so in_ready only drops
// when the queue is full, either because the receiver holds out_ready low or
// because a long run of two-result transactions outpaces the result port.
// Reset (rst_n low at a clock edge) returns the bridge to idle, empties the
// queue and sets the next bus tag to 1. While the receiver stalls, the
// presented result and its fields stay unchanged.
module axi_to_simple_bus_bridge_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_txn_id,
  input  logic [31:0] in_start_addr,
  input  logic [7:0]  in_burst_len,
  input  logic [2:0]  in_beat_size,
  input  logic [1:0]  in_burst_type,
  input  logic [31:0] in_wdata,
  input  logic [3:0]  in_wstrobe,
  input  logic        in_wlast,
  input  logic        in_rsp_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_id,
  output logic [31:0] out_bus_addr,
  output logic [31:0] out_data,
  output logic [3:0]  out_bus_strobe,
  output logic        out_bus_is_write,
  output logic [31:0] out_bus_tag,
  output logic [1:0]  out_axi_resp,
  output logic        out_rbeat_last,
  output logic        out_run_last
);

  axsb_pkg::in_item_t item;
  axsb_pkg::q_entry_t push_entry;
  axsb_pkg::q_entry_t head;
  axsb_pkg::result_t  out_res;
  logic accept, push, pop, full, empty;

  // The front only needs room for one result group to take a transaction.
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  assign item.action     = in_action;
  assign item.txn_id     = in_txn_id;
  assign item.start_addr = in_start_addr;
  assign item.burst_len  = in_burst_len;
  assign item.beat_size  = in_beat_size;
  assign item.burst_type = in_burst_type;
  assign item.wdata      = in_wdata;
  assign item.wstrobe    = in_wstrobe;
  assign item.wlast      = in_wlast;
  assign item.rsp_ok     = in_rsp_ok;

  axsb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .item       (item),
    .push       (push),
    .push_entry (push_entry)
  );

  axsb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  axsb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_id           = out_res.out_id;
  assign out_bus_addr     = out_res.bus_addr;
  assign out_data         = out_res.out_data;
  assign out_bus_strobe   = out_res.bus_strobe;
  assign out_bus_is_write = out_res.bus_is_write;
  assign out_bus_tag      = out_res.bus_tag;
  assign out_axi_resp     = out_res.axi_resp;
  assign out_rbeat_last   = out_res.rbeat_last;
  assign out_run_last     = out_res.run_last;

endmodule

FILE: sv/axsb_front.sv
// Front part of the bridge: burst state machine that classifies each input
// transaction and builds its results. Depends on axsb_pkg.
module axsb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  axsb_pkg::in_item_t  item,
  output logic                push,
  output axsb_pkg::q_entry_t  push_entry
);

  axsb_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  saved_id_r, saved_id_nxt;
  logic [31:0] cur_addr_r, cur_addr_nxt;
  logic [7:0]  saved_len_r, saved_len_nxt;
  logic [2:0]  saved_size_r, saved_size_nxt;
  logic [1:0]  saved_burst_r, saved_burst_nxt;
  logic [8:0]  beat_count_r, beat_count_nxt;
  logic        rsp_pending_r, rsp_pending_nxt;
  logic [31:0] next_tag_r, next_tag_nxt;

  logic [8:0]  len_ext;
  logic [31:0] adv_addr;
  logic        rd_last;

  assign len_ext = {1'b0, saved_len_r};
  // FIXED keeps the address; every other accepted type steps by 2^size.
  assign adv_addr = (saved_burst_r == axsb_pkg::BURST_FIXED) ? cur_addr_r :
                    cur_addr_r + (32'd1 << saved_size_r);
  assign rd_last = (beat_count_r == len_ext) || !item.rsp_ok;

  always_comb begin
    phase_nxt       = phase_r;
    saved_id_nxt    = saved_id_r;
    cur_addr_nxt    = cur_addr_r;
    saved_len_nxt   = saved_len_r;
    saved_size_nxt  = saved_size_r;
    saved_burst_nxt = saved_burst_r;
    beat_count_nxt  = beat_count_r;
    rsp_pending_nxt = rsp_pending_r;
    next_tag_nxt    = next_tag_r;
    push            = 1'b0;
    push_entry      = '0;
    if (accept) begin
      push = 1'b1;
      push_entry.res0.kind     = axsb_pkg::KIND_IGNORED;
      push_entry.res0.run_last = 1'b1;
      if (phase_r == axsb_pkg::PH_IDLE &&
          (item.action inside {axsb_pkg::ACT_RD_ADDR, axsb_pkg::ACT_WR_ADDR})) begin
        if (item.burst_type == axsb_pkg::BURST_WRAP) begin
          push_entry.res0.kind = (item.action == axsb_pkg::ACT_RD_ADDR) ?
                                 axsb_pkg::KIND_R_BEAT : axsb_pkg::KIND_B_RESP;
          push_entry.res0.out_id     = item.txn_id;
          push_entry.res0.axi_resp   = axsb_pkg::RESP_SLVERR;
          push_entry.res0.rbeat_last = (item.action == axsb_pkg::ACT_RD_ADDR);
        end else begin
          saved_id_nxt    = item.txn_id;
          cur_addr_nxt    = item.start_addr;
          saved_len_nxt   = item.burst_len;
          saved_size_nxt  = item.beat_size;
          saved_burst_nxt = item.burst_type;
          beat_count_nxt  = '0;
          if (item.action == axsb_pkg::ACT_WR_ADDR) begin
            rsp_pending_nxt = 1'b0;
            phase_nxt       = axsb_pkg::PH_WR;
            push            = 1'b0;
          end else begin
            rsp_pending_nxt = 1'b1;
            phase_nxt       = axsb_pkg::PH_RD;
            push_entry.res0.kind     = axsb_pkg::KIND_BUS_REQ;
            push_entry.res0.bus_addr = item.start_addr;
            push_entry.res0.bus_tag  = next_tag_r;
            next_tag_nxt             = next_tag_r + 32'd1;
          end
        end
      end else if (phase_r == axsb_pkg::PH_RD && item.action == axsb_pkg::ACT_BUS_RSP &&
                   rsp_pending_r) begin
        push_entry.res0.kind       = axsb_pkg::KIND_R_BEAT;
        push_entry.res0.out_id     = saved_id_r;
        push_entry.res0.out_data   = item.rsp_ok ? item.wdata : 32'd0;
        push_entry.res0.axi_resp   = item.rsp_ok ? axsb_pkg::RESP_OKAY :
                                                   axsb_pkg::RESP_SLVERR;
        push_entry.res0.rbeat_last = rd_last;
        if (rd_last) begin
          rsp_pending_nxt = 1'b0;
          phase_nxt       = axsb_pkg::PH_IDLE;
        end else begin
          // The next beat's bus read follows the returned beat.
          push_entry.res0.run_last = 1'b0;
          beat_count_nxt           = beat_count_r + 9'd1;
          cur_addr_nxt             = adv_addr;
          push_entry.two           = 1'b1;
          push_entry.res1.kind     = axsb_pkg::KIND_BUS_REQ;
          push_entry.res1.bus_addr = adv_addr;
          push_entry.res1.bus_tag  = next_tag_r;
          push_entry.res1.run_last = 1'b1;
          next_tag_nxt             = next_tag_r + 32'd1;
        end
      end else if (phase_r == axsb_pkg::PH_WR && item.action == axsb_pkg::ACT_BUS_RSP &&
                   rsp_pending_r) begin
        rsp_pending_nxt = 1'b0;
        if (!item.rsp_ok || beat_count_r > len_ext) begin
          push_entry.res0.kind     = axsb_pkg::KIND_B_RESP;
          push_entry.res0.out_id   = saved_id_r;
          push_entry.res0.axi_resp = item.rsp_ok ? axsb_pkg::RESP_OKAY :
                                                   axsb_pkg::RESP_SLVERR;
          phase_nxt                = axsb_pkg::PH_IDLE;
        end else begin
          // A good response in mid burst is absorbed.
          push = 1'b0;
        end
      end else if (phase_r == axsb_pkg::PH_WR && item.action == axsb_pkg::ACT_WR_BEAT &&
                   !rsp_pending_r && beat_count_r <= len_ext) begin
        push_entry.res0.kind         = axsb_pkg::KIND_BUS_REQ;
        push_entry.res0.bus_addr     = cur_addr_r;
        push_entry.res0.out_data     = item.wdata;
        push_entry.res0.bus_strobe   = item.wstrobe;
        push_entry.res0.bus_is_write = 1'b1;
        push_entry.res0.bus_tag      = next_tag_r;
        next_tag_nxt                 = next_tag_r + 32'd1;
        rsp_pending_nxt              = 1'b1;
        if (item.wlast) begin
          beat_count_nxt = len_ext + 9'd1;
        end else begin
          cur_addr_nxt   = adv_addr;
          beat_count_nxt = beat_count_r + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= axsb_pkg::PH_IDLE;
      saved_id_r    <= '0;
      cur_addr_r    <= '0;
      saved_len_r   <= '0;
      saved_size_r  <= '0;
      saved_burst_r <= '0;
      beat_count_r  <= '0;
      rsp_pending_r <= 1'b0;
      next_tag_r    <= 32'd1;
    end else begin
      phase_r       <= phase_nxt;
      saved_id_r    <= saved_id_nxt;
      cur_addr_r    <= cur_addr_nxt;
      saved_len_r   <= saved_len_nxt;
      saved_size_r  <= saved_size_nxt;
      saved_burst_r <= saved_burst_nxt;
      beat_count_r  <= beat_count_nxt;
      rsp_pending_r <= rsp_pending_nxt;
      next_tag_r    <= next_tag_nxt;
    end
  end

endmodule

FILE: sv/axsb_queue.sv
// Short result queue between the front and back parts of the bridge.
// Depends on axsb_pkg.
module axsb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  axsb_pkg::q_entry_t  push_entry,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output axsb_pkg::q_entry_t  head
);

  axsb_pkg::q_entry_t mem_r [axsb_pkg::QDepth];
  logic [axsb_pkg::QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [axsb_pkg::QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [axsb_pkg::QCntW-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full    = (count_r == axsb_pkg::QCntW'(axsb_pkg::QDepth));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: sv/axsb_back.sv
// Back part of the bridge: sends the one or two results of each queue
// entry on the result channel in order. Depends on axsb_pkg.
module axsb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  input  axsb_pkg::q_entry_t  head,
  output logic                pop,
  input  logic                out_ready,
  output logic                out_valid,
  output axsb_pkg::result_t   out_res
);

  logic sel_r, sel_nxt;
  logic take;

  assign out_valid = !empty;
  assign out_res   = sel_r ? head.res1 : head.res0;
  assign take      = out_valid && out_ready;
  assign pop       = take && (sel_r || !head.two);

  always_comb begin
    sel_nxt = sel_r;
    if (take) begin
      sel_nxt = !pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule
